>>> design/packed_row_index_table_macros.svh
// ----------------------------------------------------------------------------
// packed_row_index_table_macros.svh
// Assertion macros used by the checker file prt_checker.sv.
// ----------------------------------------------------------------------------
`ifndef PACKED_ROW_INDEX_TABLE_MACROS_SVH
`define PACKED_ROW_INDEX_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Field widths, codes and shared types of the packed row index table.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int MODE_W = 2;
  localparam int ID_W   = 8;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int STAT_W = 2;

  // free-id search group size
  localparam int GRP       = 16;
  localparam int GRP_POS_W = 4;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FREE = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_DELETE,
    OP_LOOKUP
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } stat_t;

endpackage

>>> design/prt_in_if.sv
// ----------------------------------------------------------------------------
// prt_in_if
// Request channel: operation mode and row id.
// ----------------------------------------------------------------------------
interface prt_in_if;
  logic                        valid;
  logic                        ready;
  logic [prt_pkg::MODE_W-1:0]  mode;
  logic [prt_pkg::ID_W-1:0]    row_id;

  modport source (output valid, output mode, output row_id, input ready);
  modport sink   (input valid, input mode, input row_id, output ready);
endinterface

>>> design/prt_out_if.sv
// ----------------------------------------------------------------------------
// prt_out_if
// Result channel: id, packed index, live count and status.
// ----------------------------------------------------------------------------
interface prt_out_if;
  logic                        valid;
  logic                        ready;
  logic [prt_pkg::ID_W-1:0]    given_id;
  logic [prt_pkg::IDX_W-1:0]   packed_index;
  logic [prt_pkg::CNT_W-1:0]   live_count;
  logic [prt_pkg::STAT_W-1:0]  status;

  modport source (output valid, output given_id, output packed_index,
                  output live_count, output status, input ready);
  modport sink   (input valid, input given_id, input packed_index,
                  input live_count, input status, output ready);
endinterface

>>> design/prt_ram.sv
// ----------------------------------------------------------------------------
// prt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/prt_ctrl.sv
// ----------------------------------------------------------------------------
// prt_ctrl
// Sequencer: accepts a request, then commits it once the result register
// can take the result.
// ----------------------------------------------------------------------------
module prt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prt_pkg::stat_t st,
  output prt_pkg::cmd_t  cmd
);

  prt_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = prt_pkg::S_EXEC;
        end
      end
      prt_pkg::S_EXEC: begin
        if (!st.out_blocked) begin
          state_nxt = prt_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      prt_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      prt_pkg::S_EXEC: begin
        cmd.commit = !st.out_blocked;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/prt_dp.sv
// ----------------------------------------------------------------------------
// prt_dp
// Datapath: live-id bitmap, free-id search, row count, the two index maps
// and the result register.
// ----------------------------------------------------------------------------
module prt_dp #(
  parameter int MAX_ROWS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prt_pkg::cmd_t                cmd,
  output prt_pkg::stat_t               st,
  input  logic [prt_pkg::MODE_W-1:0]   mode,
  input  logic [prt_pkg::ID_W-1:0]     row_id,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [prt_pkg::ID_W-1:0]     given_id,
  output logic [prt_pkg::IDX_W-1:0]    packed_index,
  output logic [prt_pkg::CNT_W-1:0]    live_count,
  output logic [prt_pkg::STAT_W-1:0]   status
);

  localparam int IW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_ROWS + 1);
  localparam int NG  = (MAX_ROWS + prt_pkg::GRP - 1) / prt_pkg::GRP;
  localparam int NGW = (NG > 1) ? $clog2(NG) : 1;
  localparam int RW  = IW + prt_pkg::ID_W + 1;
  localparam int FW  = NGW + prt_pkg::GRP_POS_W;

  // live-id bitmap and count
  logic [MAX_ROWS-1:0] used_r, used_nxt;
  logic [CW-1:0]       count_r, count_nxt, count_after, count_m1;
  logic [NG*prt_pkg::GRP-1:0] used_pad;

  // request decode
  logic [RW-1:0]  rid_wide;
  logic           rid_in_range;
  logic [IW-1:0]  rid_idx;
  logic           rid_live;
  logic           table_full;
  prt_pkg::op_t   op_dec;

  // captured request
  prt_pkg::op_t              op_r;
  logic                      err_r;
  logic [prt_pkg::ID_W-1:0]  rid_r;
  logic [IW-1:0]             rid_idx_r;

  // free-id search, first stage per group, second stage across groups
  logic [NG-1:0]                        grp_free, grp_free_r;
  logic [NG-1:0][prt_pkg::GRP_POS_W-1:0] grp_pos, grp_pos_r;
  logic [NGW-1:0]                       sel_grp;
  logic [prt_pkg::GRP_POS_W-1:0]        sel_pos;
  logic [FW-1:0]                        free_wide;
  logic [IW-1:0]                        new_id;

  // maps
  logic           map_we;
  logic [IW-1:0]  freed_idx;
  logic [IW-1:0]  last_id;
  logic [IW-1:0]  i2x_wr_addr, i2x_wr_data;
  logic [IW-1:0]  x2i_wr_addr, x2i_wr_data;

  // result
  logic [IW-1:0]                res_id, res_idx;
  logic                         res_use_rid;
  logic [prt_pkg::STAT_W-1:0]   res_status;
  logic [IW+prt_pkg::ID_W-1:0]  res_id_wide;
  logic [IW+prt_pkg::IDX_W-1:0] res_idx_wide;
  logic [CW+prt_pkg::CNT_W-1:0] res_cnt_wide;

  logic                         out_valid_r, out_valid_nxt;
  logic [prt_pkg::ID_W-1:0]     given_r;
  logic [prt_pkg::IDX_W-1:0]    index_r;
  logic [prt_pkg::CNT_W-1:0]    live_r;
  logic [prt_pkg::STAT_W-1:0]   status_r;

  always_comb begin
    used_pad = '1;
    used_pad[MAX_ROWS-1:0] = used_r;
  end

  assign rid_wide     = RW'(row_id);
  assign rid_in_range = rid_wide < RW'(MAX_ROWS);
  assign rid_idx      = rid_wide[IW-1:0];
  assign rid_live     = rid_in_range && used_r[rid_idx];
  assign table_full   = count_r == CW'(MAX_ROWS);
  assign count_m1     = count_r - CW'(1);

  always_comb begin
    priority if (mode == prt_pkg::MODE_ALLOC) begin
      op_dec = prt_pkg::OP_ALLOC;
    end else if (mode == prt_pkg::MODE_DELETE) begin
      op_dec = prt_pkg::OP_DELETE;
    end else begin
      op_dec = prt_pkg::OP_LOOKUP;
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_free[g] = ~&used_pad[g*prt_pkg::GRP +: prt_pkg::GRP];
      grp_pos[g]  = '0;
      for (int j = prt_pkg::GRP - 1; j >= 0; j--) begin
        if (!used_pad[g*prt_pkg::GRP + j]) begin
          grp_pos[g] = prt_pkg::GRP_POS_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= op_dec;
      err_r      <= (op_dec == prt_pkg::OP_ALLOC) ? table_full : !rid_live;
      rid_r      <= row_id;
      rid_idx_r  <= rid_idx;
      grp_free_r <= grp_free;
      grp_pos_r  <= grp_pos;
    end
  end

  always_comb begin
    sel_grp = '0;
    sel_pos = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        sel_grp = NGW'(g);
        sel_pos = grp_pos_r[g];
      end
    end
  end

  assign free_wide = {sel_grp, sel_pos};
  assign new_id    = free_wide[IW-1:0];

  assign map_we = cmd.commit && !err_r && (op_r != prt_pkg::OP_LOOKUP);

  always_comb begin
    if (op_r == prt_pkg::OP_ALLOC) begin
      i2x_wr_addr = new_id;
      i2x_wr_data = count_r[IW-1:0];
      x2i_wr_addr = count_r[IW-1:0];
      x2i_wr_data = new_id;
    end else begin
      i2x_wr_addr = last_id;
      i2x_wr_data = freed_idx;
      x2i_wr_addr = freed_idx;
      x2i_wr_data = last_id;
    end
  end

  prt_ram #(.WIDTH(IW), .DEPTH(MAX_ROWS)) u_id_to_index (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (i2x_wr_addr),
    .wr_data (i2x_wr_data),
    .rd_en   (cmd.capture),
    .rd_addr (rid_idx),
    .rd_data (freed_idx)
  );

  prt_ram #(.WIDTH(IW), .DEPTH(MAX_ROWS)) u_index_to_id (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (x2i_wr_addr),
    .wr_data (x2i_wr_data),
    .rd_en   (cmd.capture),
    .rd_addr (count_m1[IW-1:0]),
    .rd_data (last_id)
  );

  always_comb begin
    count_after = count_r;
    if (!err_r && op_r == prt_pkg::OP_ALLOC) begin
      count_after = count_r + CW'(1);
    end else if (!err_r && op_r == prt_pkg::OP_DELETE) begin
      count_after = count_m1;
    end
  end

  always_comb begin
    used_nxt  = used_r;
    count_nxt = count_r;
    if (cmd.commit) begin
      count_nxt = count_after;
      if (!err_r && op_r == prt_pkg::OP_ALLOC) begin
        used_nxt[new_id] = 1'b1;
      end else if (!err_r && op_r == prt_pkg::OP_DELETE) begin
        used_nxt[rid_idx_r] = 1'b0;
      end
    end
  end

  always_comb begin
    res_id      = '0;
    res_idx     = '0;
    res_use_rid = 1'b1;
    res_status  = prt_pkg::ST_OK;
    unique case (op_r)
      prt_pkg::OP_ALLOC: begin
        res_use_rid = 1'b0;
        if (err_r) begin
          res_status = prt_pkg::ST_FULL;
        end else begin
          res_id  = new_id;
          res_idx = count_r[IW-1:0];
        end
      end
      prt_pkg::OP_DELETE, prt_pkg::OP_LOOKUP: begin
        if (err_r) begin
          res_status = prt_pkg::ST_FREE;
        end else begin
          res_idx = freed_idx;
        end
      end
      default: begin
        res_status = prt_pkg::ST_FREE;
      end
    endcase
  end

  assign res_id_wide  = (IW + prt_pkg::ID_W)'(res_id);
  assign res_idx_wide = (IW + prt_pkg::IDX_W)'(res_idx);
  assign res_cnt_wide = (CW + prt_pkg::CNT_W)'(count_after);

  assign out_valid_nxt  = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign st.out_blocked = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      given_r  <= res_use_rid ? rid_r : res_id_wide[prt_pkg::ID_W-1:0];
      index_r  <= res_idx_wide[prt_pkg::IDX_W-1:0];
      live_r   <= res_cnt_wide[prt_pkg::CNT_W-1:0];
      status_r <= res_status;
    end
  end

  assign out_valid    = out_valid_r;
  assign given_id     = given_r;
  assign packed_index = index_r;
  assign live_count   = live_r;
  assign status       = status_r;

endmodule

>>> design/packed_row_index_table.sv
// ----------------------------------------------------------------------------
// packed_row_index_table
// Sparse-set slot map: dense pack of live rows with id-to-index and
// index-to-id maps, allocate / delete / lookup with one result per request.
// ----------------------------------------------------------------------------
// For each request, the accept cycle decodes it, starts the per-group
// free-id search and issues one read to each of the two map RAMs; the
// commit in S_EXEC, once the result register can take it, resolves the
// lowest free id, performs the map writes and loads the result register.
// A new request is accepted while a result waits in the result register;
// if that result is still untaken when the next request is ready to
// commit, the block holds until it is taken. The live-id bitmap is
// cleared by reset at once, so there is no clearing pass after reset.
module packed_row_index_table #(
  parameter int MAX_ROWS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  prt_in_if.sink    in_ch,
  prt_out_if.source out_ch
);

  prt_pkg::cmd_t  cmd;
  prt_pkg::stat_t st;

  prt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  prt_dp #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .mode         (in_ch.mode),
    .row_id       (in_ch.row_id),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .given_id     (out_ch.given_id),
    .packed_index (out_ch.packed_index),
    .live_count   (out_ch.live_count),
    .status       (out_ch.status)
  );

endmodule

>>> design/prt_checker.sv
// ----------------------------------------------------------------------------
// prt_checker
// Port-level checks of the packed row index table, bound to the top level.
// ----------------------------------------------------------------------------
`include "packed_row_index_table_macros.svh"

module prt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [prt_pkg::ID_W-1:0]    given_id,
  input logic [prt_pkg::IDX_W-1:0]   packed_index,
  input logic [prt_pkg::CNT_W-1:0]   live_count,
  input logic [prt_pkg::STAT_W-1:0]  status
);

  logic                       out_xfer;
  logic [prt_pkg::CNT_W-1:0]  last_cnt_r;

  assign out_xfer = out_valid && out_ready;

  // live count seen on the previous transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
    end else if (out_xfer) begin
      last_cnt_r <= live_count;
    end
  end

  `PRT_ASSERT_NEXT(a_in_one_at_a_time, in_valid && in_ready, !in_ready, "request accepted twice in a row")
  `PRT_ASSERT_SAME(a_count_step, out_xfer, live_count == last_cnt_r || live_count == last_cnt_r + 9'd1 || live_count + 9'd1 == last_cnt_r, "live count jumped by more than one")
  `PRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")
  `PRT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(given_id) && $stable(packed_index) && $stable(live_count) && $stable(status), "stalled result changed")

endmodule

bind packed_row_index_table prt_checker u_prt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .given_id     (out_ch.given_id),
  .packed_index (out_ch.packed_index),
  .live_count   (out_ch.live_count),
  .status       (out_ch.status)
);
